/* hdl/ssg_pkg.sv */
// ---------------------------------------------------------------------------
// ssg_pkg
// Shared types and constants of the scrambled Sobol sample generator.
// ---------------------------------------------------------------------------
`default_nettype none

package ssg_pkg;

  localparam int NUM_DIMENSIONS_DEF = 1024;
  localparam int MATRIX_SIZE_DEF    = 52;
  localparam int MAX_LOG2_RES_DEF   = 16;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCRAMBLE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOG2_RES = 1'b1;

  typedef enum logic [2:0] {
    OP_LOAD_COL    = 3'd0,
    OP_LOAD_FWD    = 3'd1,
    OP_LOAD_INV    = 3'd2,
    OP_START_PIXEL = 3'd3,
    OP_DRAW        = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FWD,
    ST_FWD_WAIT,
    ST_INV,
    ST_INV_WAIT,
    ST_DRAW_SEL,
    ST_DRAW,
    ST_DRAW_WAIT
  } state_e;

endpackage

`default_nettype wire

/* hdl/sobol_sample_generator_top.sv */
// ---------------------------------------------------------------------------
// sobol_sample_generator_top
// Scrambled Sobol sample generator: column tables in on-chip memories,
// one column read per cycle and folded into an xor accumulator.
//
//   channel   ports                                   handshake
//   -------   -------------------------------------   -------------------
//   command   opcode_i .. draw_count_i                start_i / busy_o
//   config    cfg_index_i, cfg_wdata_i                cfg_we_i
//   result    sample_fraction_o .. last_result_o      result_valid_o
//
// start pixel reads the forward and then the inverse table serially
// (no reads when the resolution is zero); a draw reads the column store
// through its single read port for each valid dimension and not for an
// invalid one. results are registered after their last read and cannot
// be stalled. reset clears the control state and the configuration
// registers; the tables and payload registers hold no reset value.
// ---------------------------------------------------------------------------
`default_nettype none

module sobol_sample_generator_top #(
  parameter int NUM_DIMENSIONS = ssg_pkg::NUM_DIMENSIONS_DEF,
  parameter int MATRIX_SIZE    = ssg_pkg::MATRIX_SIZE_DEF,
  parameter int MAX_LOG2_RES   = ssg_pkg::MAX_LOG2_RES_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output      logic                         busy_o,
  input  wire logic [2:0]                   opcode_i,
  input  wire logic [15:0]                  table_address_i,
  input  wire logic [63:0]                  load_value_i,
  input  wire logic [15:0]                  pixel_x_i,
  input  wire logic [15:0]                  pixel_y_i,
  input  wire logic [31:0]                  sample_number_i,
  input  wire logic [2:0]                   draw_count_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [ssg_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [31:0]                  cfg_wdata_i,
  output      logic                         result_valid_o,
  output      logic [31:0]                  sample_fraction_o,
  output      logic [63:0]                  sequence_index_o,
  output      logic                         dimension_invalid_o,
  output      logic                         last_result_o
);

  localparam int GEN_DEPTH = NUM_DIMENSIONS * MATRIX_SIZE;
  localparam int VDC_DEPTH = MAX_LOG2_RES * MATRIX_SIZE;
  localparam int GEN_AW    = $clog2(GEN_DEPTH);
  localparam int VDC_AW    = $clog2(VDC_DEPTH);
  localparam int CNT_W     = $clog2(MATRIX_SIZE);
  localparam int FWD_N     = (MATRIX_SIZE < 32) ? MATRIX_SIZE : 32;

  // memories
  logic [31:0] gen_mem [GEN_DEPTH];
  logic [63:0] fwd_mem [VDC_DEPTH];
  logic [63:0] inv_mem [VDC_DEPTH];
  logic [31:0] gen_rdata_q;
  logic [63:0] fwd_rdata_q;
  logic [63:0] inv_rdata_q;

  ssg_pkg::state_e state_q, state_d;

  logic [31:0]       scramble_q;
  logic [4:0]        log2_res_q;
  logic [63:0]       cur_index_q, cur_index_d;
  logic [15:0]       dim_q, dim_d;
  logic [2:0]        remain_q, remain_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              en_q, en_d;
  logic [63:0]       sel_q, sel_d;
  logic [63:0]       acc_q, acc_d;
  logic [VDC_AW-1:0] row_q, row_d;
  logic [VDC_AW-1:0] vdc_addr_q, vdc_addr_d;
  logic [GEN_AW-1:0] gen_addr_q, gen_addr_d;
  logic [4:0]        m_q, m_d;
  logic [15:0]       px_q, px_d;
  logic [15:0]       py_q, py_d;
  logic [31:0]       sample_q, sample_d;

  logic        out_valid_q, out_valid_d;
  logic [31:0] out_frac_q, out_frac_d;
  logic [63:0] out_seq_q, out_seq_d;
  logic        out_inv_q, out_inv_d;
  logic        out_last_q, out_last_d;

  logic        accept;
  logic        issuing;
  logic        cnt_last;
  logic        dim_bad;
  logic        rem_last;
  logic [4:0]  m_sat;
  logic [2:0]  count_sat;
  logic [31:0] addr_ext;
  logic        gen_we;
  logic        fwd_we;
  logic        inv_we;
  logic [63:0] fwd_fold;
  logic [63:0] inv_fold;
  logic [31:0] gen_fold;
  logic [63:0] pix_word;

  assign accept   = start_i && (state_q == ssg_pkg::ST_IDLE);
  assign busy_o   = (state_q != ssg_pkg::ST_IDLE);
  assign issuing  = (state_q == ssg_pkg::ST_FWD) || (state_q == ssg_pkg::ST_INV) ||
                    (state_q == ssg_pkg::ST_DRAW);
  assign cnt_last = (state_q == ssg_pkg::ST_FWD) ? (cnt_q == CNT_W'(FWD_N - 1))
                                                 : (cnt_q == CNT_W'(MATRIX_SIZE - 1));
  assign dim_bad  = (dim_q >= 16'(NUM_DIMENSIONS));
  assign rem_last = (remain_q == 3'd1);
  assign m_sat    = (log2_res_q > 5'(MAX_LOG2_RES)) ? 5'(MAX_LOG2_RES) : log2_res_q;
  assign addr_ext = {16'b0, table_address_i};

  always_comb begin
    case (draw_count_i) inside
      3'd0:       count_sat = 3'd1;
      [3'd6:3'd7]: count_sat = 3'd5;
      default:    count_sat = draw_count_i;
    endcase
  end

  assign gen_we = accept && (opcode_i == ssg_pkg::OP_LOAD_COL) && (addr_ext < 32'(GEN_DEPTH));
  assign fwd_we = accept && (opcode_i == ssg_pkg::OP_LOAD_FWD) && (addr_ext < 32'(VDC_DEPTH));
  assign inv_we = accept && (opcode_i == ssg_pkg::OP_LOAD_INV) && (addr_ext < 32'(VDC_DEPTH));

  always_ff @(posedge clk_i) begin
    if (gen_we) begin
      gen_mem[addr_ext[GEN_AW-1:0]] <= load_value_i[31:0];
    end
    gen_rdata_q <= gen_mem[gen_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (fwd_we) begin
      fwd_mem[addr_ext[VDC_AW-1:0]] <= load_value_i;
    end
    fwd_rdata_q <= fwd_mem[vdc_addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (inv_we) begin
      inv_mem[addr_ext[VDC_AW-1:0]] <= load_value_i;
    end
    inv_rdata_q <= inv_mem[vdc_addr_q];
  end

  // folded accumulator values for the cycle after the last read
  assign fwd_fold = acc_q ^ (en_q ? fwd_rdata_q : 64'b0);
  assign inv_fold = acc_q ^ (en_q ? inv_rdata_q : 64'b0);
  assign gen_fold = acc_q[31:0] ^ (en_q ? gen_rdata_q : 32'b0);
  assign pix_word = (({48'b0, px_q} << m_q) | {48'b0, py_q}) ^ fwd_fold;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ssg_pkg::ST_IDLE: begin
        if (accept) begin
          case (opcode_i)
            ssg_pkg::OP_START_PIXEL: begin
              if (log2_res_q != 5'd0) begin
                state_d = ssg_pkg::ST_FWD;
              end
            end
            ssg_pkg::OP_DRAW: state_d = ssg_pkg::ST_DRAW_SEL;
            default:          state_d = ssg_pkg::ST_IDLE;
          endcase
        end
      end
      ssg_pkg::ST_FWD: begin
        if (cnt_last) begin
          state_d = ssg_pkg::ST_FWD_WAIT;
        end
      end
      ssg_pkg::ST_FWD_WAIT: state_d = ssg_pkg::ST_INV;
      ssg_pkg::ST_INV: begin
        if (cnt_last) begin
          state_d = ssg_pkg::ST_INV_WAIT;
        end
      end
      ssg_pkg::ST_INV_WAIT: state_d = ssg_pkg::ST_IDLE;
      ssg_pkg::ST_DRAW_SEL: begin
        if (!dim_bad) begin
          state_d = ssg_pkg::ST_DRAW;
        end else if (rem_last) begin
          state_d = ssg_pkg::ST_IDLE;
        end
      end
      ssg_pkg::ST_DRAW: begin
        if (cnt_last) begin
          state_d = ssg_pkg::ST_DRAW_WAIT;
        end
      end
      ssg_pkg::ST_DRAW_WAIT: state_d = rem_last ? ssg_pkg::ST_IDLE : ssg_pkg::ST_DRAW_SEL;
      default: state_d = ssg_pkg::ST_IDLE;
    endcase
  end

  // datapath and results
  always_comb begin
    cur_index_d = cur_index_q;
    dim_d       = dim_q;
    remain_d    = remain_q;
    cnt_d       = (issuing && !cnt_last) ? cnt_q + CNT_W'(1) : '0;
    en_d        = issuing && sel_q[0];
    sel_d       = issuing ? (sel_q >> 1) : sel_q;
    acc_d       = acc_q;
    row_d       = row_q;
    vdc_addr_d  = vdc_addr_q;
    gen_addr_d  = gen_addr_q;
    m_d         = m_q;
    px_d        = px_q;
    py_d        = py_q;
    sample_d    = sample_q;
    out_valid_d = 1'b0;
    out_frac_d  = out_frac_q;
    out_seq_d   = out_seq_q;
    out_inv_d   = out_inv_q;
    out_last_d  = out_last_q;

    case (state_q)
      ssg_pkg::ST_IDLE: begin
        if (accept && (opcode_i == ssg_pkg::OP_START_PIXEL)) begin
          if (log2_res_q == 5'd0) begin
            cur_index_d = '0;
            dim_d       = '0;
            out_valid_d = 1'b1;
            out_frac_d  = '0;
            out_seq_d   = '0;
            out_inv_d   = 1'b0;
            out_last_d  = 1'b1;
          end else begin
            m_d        = m_sat;
            px_d       = pixel_x_i;
            py_d       = pixel_y_i;
            sample_d   = sample_number_i;
            row_d      = VDC_AW'(m_sat - 5'd1) * VDC_AW'(MATRIX_SIZE);
            vdc_addr_d = VDC_AW'(m_sat - 5'd1) * VDC_AW'(MATRIX_SIZE);
            sel_d      = {32'b0, sample_number_i};
            acc_d      = '0;
          end
        end else if (accept && (opcode_i == ssg_pkg::OP_DRAW)) begin
          remain_d = count_sat;
        end
      end
      ssg_pkg::ST_FWD: begin
        if (en_q) begin
          acc_d = acc_q ^ fwd_rdata_q;
        end
        vdc_addr_d = cnt_last ? row_q : vdc_addr_q + VDC_AW'(1);
      end
      ssg_pkg::ST_FWD_WAIT: begin
        sel_d = pix_word;
        acc_d = {32'b0, sample_q} << {m_q, 1'b0};
      end
      ssg_pkg::ST_INV: begin
        if (en_q) begin
          acc_d = acc_q ^ inv_rdata_q;
        end
        vdc_addr_d = vdc_addr_q + VDC_AW'(1);
      end
      ssg_pkg::ST_INV_WAIT: begin
        cur_index_d = inv_fold;
        dim_d       = '0;
        out_valid_d = 1'b1;
        out_frac_d  = '0;
        out_seq_d   = inv_fold;
        out_inv_d   = 1'b0;
        out_last_d  = 1'b1;
      end
      ssg_pkg::ST_DRAW_SEL: begin
        if (dim_bad) begin
          out_valid_d = 1'b1;
          out_frac_d  = '0;
          out_seq_d   = cur_index_q;
          out_inv_d   = 1'b1;
          out_last_d  = rem_last;
          dim_d       = dim_q + 16'd1;
          remain_d    = remain_q - 3'd1;
        end else begin
          gen_addr_d = GEN_AW'(dim_q) * GEN_AW'(MATRIX_SIZE) + GEN_AW'(MATRIX_SIZE - 1);
          sel_d      = cur_index_q;
          acc_d      = {32'b0, scramble_q};
        end
      end
      ssg_pkg::ST_DRAW: begin
        if (en_q) begin
          acc_d = acc_q ^ {32'b0, gen_rdata_q};
        end
        gen_addr_d = gen_addr_q - GEN_AW'(1);
      end
      ssg_pkg::ST_DRAW_WAIT: begin
        out_valid_d = 1'b1;
        out_frac_d  = gen_fold;
        out_seq_d   = cur_index_q;
        out_inv_d   = 1'b0;
        out_last_d  = rem_last;
        dim_d       = dim_q + 16'd1;
        remain_d    = remain_q - 3'd1;
      end
      default: begin
        out_valid_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ssg_pkg::ST_IDLE;
      scramble_q  <= '0;
      log2_res_q  <= '0;
      cur_index_q <= '0;
      dim_q       <= '0;
      remain_q    <= '0;
      cnt_q       <= '0;
      en_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cur_index_q <= cur_index_d;
      dim_q       <= dim_d;
      remain_q    <= remain_d;
      cnt_q       <= cnt_d;
      en_q        <= en_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i && (cfg_index_i == ssg_pkg::CFG_SCRAMBLE)) begin
        scramble_q <= cfg_wdata_i;
      end
      if (cfg_we_i && (cfg_index_i == ssg_pkg::CFG_LOG2_RES)) begin
        log2_res_q <= cfg_wdata_i[4:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    sel_q      <= sel_d;
    acc_q      <= acc_d;
    row_q      <= row_d;
    vdc_addr_q <= vdc_addr_d;
    gen_addr_q <= gen_addr_d;
    m_q        <= m_d;
    px_q       <= px_d;
    py_q       <= py_d;
    sample_q   <= sample_d;
    out_frac_q <= out_frac_d;
    out_seq_q  <= out_seq_d;
    out_inv_q  <= out_inv_d;
    out_last_q <= out_last_d;
  end

  assign result_valid_o      = out_valid_q;
  assign sample_fraction_o   = out_frac_q;
  assign sequence_index_o    = out_seq_q;
  assign dimension_invalid_o = out_inv_q;
  assign last_result_o       = out_last_q;

endmodule

`default_nettype wire
